FILE: hw/rtl/alr_pkg.sv
// Shared types and constants for the additive lagged random number generator.
`timescale 1ns / 1ps

package alr_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned SHUFFLE_ROUNDS = 10;

  localparam logic [WORD_W-1:0] SEED_MULT = 32'd1103515245;
  localparam logic [WORD_W-1:0] SEED_ADD = 32'd12345;

  localparam logic ACT_DRAW = 1'b0;
  localparam logic ACT_RESEED = 1'b1;

  // Request and result payloads
  typedef struct packed {
    logic              action;
    logic [WORD_W-1:0] seed;
    logic [WORD_W-1:0] bound;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] scaled_value;
    logic [WORD_W-1:0] raw_value;
  } rsp_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_READ,
    ST_WRITE,
    ST_MOD
  } state_t;

endpackage

FILE: hw/rtl/alr_rem.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps

module alr_rem (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [alr_pkg::WORD_W-1:0]     dividend,
  input  logic [alr_pkg::WORD_W-1:0]     divisor,
  output logic                           busy,
  output logic [alr_pkg::WORD_W-1:0]     remainder
);

  localparam int unsigned SW = $clog2(alr_pkg::DIV_STEPS);

  logic [alr_pkg::WORD_W-1:0] rem;
  logic [alr_pkg::WORD_W-1:0] dvd;
  logic [alr_pkg::WORD_W-1:0] dvs;
  logic [SW-1:0]              step;
  logic [alr_pkg::WORD_W:0]   shifted;
  logic [alr_pkg::WORD_W:0]   diff;
  logic [alr_pkg::WORD_W-1:0] rem_next;

  // One shift-and-subtract step
  always_comb begin
    shifted = {rem, dvd[alr_pkg::WORD_W-1]};
    diff = shifted - {1'b0, dvs};
    if (diff[alr_pkg::WORD_W]) begin
      rem_next = shifted[alr_pkg::WORD_W-1:0];
    end else begin
      rem_next = diff[alr_pkg::WORD_W-1:0];
    end
  end

  // Control: step counter and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + SW'(1);
      if (step == SW'(alr_pkg::DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= {dvd[alr_pkg::WORD_W-2:0], 1'b0};
    end
  end

  assign remainder = rem;

endmodule

FILE: hw/rtl/additive_lagged_rng_top.sv
// Top level of the additive lagged random number generator.
`timescale 1ns / 1ps

// Additive lagged generator over a ring of RING_SIZE 32-bit words held in a
// two-read, one-write memory. One request is handled at a time; req_stall is
// high while a request is in progress. A draw reads the front and rear
// words, then adds and writes back the sum, then waits on the bit-serial
// remainder unit for the result. A reseed fills the ring word by word
// through the seed multiplier, then makes 10 * RING_SIZE discarded draws,
// each a read, then an add and write. A reseed gives no result. After reset
// the ring reads as all zero. The result register lets a new request be
// accepted while a result is still stalled; a draw waits at its end only if
// the previous result is still held.

module additive_lagged_rng_top #(
  parameter int unsigned RING_SIZE = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  alr_pkg::req_t req_data,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output alr_pkg::rsp_t rsp_data
);

  localparam int unsigned IW = (RING_SIZE > 2) ? $clog2(RING_SIZE) : 1;
  localparam int unsigned SHUF = alr_pkg::SHUFFLE_ROUNDS * RING_SIZE;
  localparam int unsigned CW = $clog2(SHUF + 1);
  localparam int unsigned WW = alr_pkg::WORD_W;

  alr_pkg::state_t state;
  alr_pkg::state_t state_next;

  logic [WW-1:0]        mem [RING_SIZE];
  logic [RING_SIZE-1:0] vld;
  logic [WW-1:0]        rd_front;
  logic [WW-1:0]        rd_rear;
  logic                 rd_front_vld;
  logic                 rd_rear_vld;

  logic [IW-1:0] front;
  logic [IW-1:0] rear;
  logic [IW-1:0] front_next;
  logic [IW-1:0] rear_next;
  logic [IW-1:0] idx;
  logic [CW-1:0] cnt;
  logic          shuffle;
  logic [WW-1:0] acc;
  logic [WW-1:0] acc_next;
  logic [WW-1:0] bound;
  logic [WW-1:0] raw;
  logic [WW-1:0] sum;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [WW-1:0] mem_wdata;
  logic          div_start;
  logic          div_busy;
  logic [WW-1:0] div_rem;
  logic          rsp_free;
  logic          accept;

  assign accept = req_valid && !req_stall;
  assign rsp_free = !rsp_valid || !rsp_stall;

  // Seed chain and draw adder
  assign acc_next = acc * alr_pkg::SEED_MULT + alr_pkg::SEED_ADD;
  assign sum = (rd_front_vld ? rd_front : '0) + (rd_rear_vld ? rd_rear : '0);

  // Index advance, rear stays one behind front
  assign front_next = (front == IW'(RING_SIZE - 1)) ? '0 : front + IW'(1);
  assign rear_next = (rear == IW'(RING_SIZE - 1)) ? '0 : rear + IW'(1);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      alr_pkg::ST_IDLE: begin
        if (req_valid) begin
          if (req_data.action == alr_pkg::ACT_RESEED) begin
            state_next = alr_pkg::ST_FILL;
          end else begin
            state_next = alr_pkg::ST_READ;
          end
        end
      end
      alr_pkg::ST_FILL: begin
        if (idx == IW'(RING_SIZE - 1)) begin
          state_next = alr_pkg::ST_READ;
        end
      end
      alr_pkg::ST_READ: begin
        state_next = alr_pkg::ST_WRITE;
      end
      alr_pkg::ST_WRITE: begin
        if (!shuffle) begin
          state_next = alr_pkg::ST_MOD;
        end else if (cnt == CW'(1)) begin
          state_next = alr_pkg::ST_IDLE;
        end else begin
          state_next = alr_pkg::ST_READ;
        end
      end
      alr_pkg::ST_MOD: begin
        if (!div_busy && rsp_free) begin
          state_next = alr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = alr_pkg::ST_IDLE;
      end
    endcase
  end

  // Control outputs
  always_comb begin
    req_stall = 1'b1;
    mem_we = 1'b0;
    mem_waddr = front;
    mem_wdata = sum;
    div_start = 1'b0;
    case (state)
      alr_pkg::ST_IDLE: begin
        req_stall = 1'b0;
      end
      alr_pkg::ST_FILL: begin
        mem_we = 1'b1;
        mem_waddr = idx;
        mem_wdata = acc;
      end
      alr_pkg::ST_WRITE: begin
        mem_we = 1'b1;
        div_start = !shuffle;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  // Ring memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_front <= mem[front];
    rd_rear <= mem[rear];
  end

  // Word valid bits: unwritten words read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      rd_front_vld <= 1'b0;
      rd_rear_vld <= 1'b0;
    end else begin
      if (mem_we) begin
        vld[mem_waddr] <= 1'b1;
      end
      rd_front_vld <= vld[front];
      rd_rear_vld <= vld[rear];
    end
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= alr_pkg::ST_IDLE;
      front <= IW'(1);
      rear <= '0;
      shuffle <= 1'b0;
      cnt <= '0;
      idx <= '0;
    end else begin
      state <= state_next;
      case (state)
        alr_pkg::ST_IDLE: begin
          if (accept) begin
            idx <= '0;
            cnt <= CW'(SHUF);
            shuffle <= (req_data.action == alr_pkg::ACT_RESEED);
          end
        end
        alr_pkg::ST_FILL: begin
          idx <= idx + IW'(1);
          if (idx == IW'(RING_SIZE - 1)) begin
            front <= IW'(1);
            rear <= '0;
          end
        end
        alr_pkg::ST_WRITE: begin
          front <= front_next;
          rear <= rear_next;
          if (shuffle) begin
            cnt <= cnt - CW'(1);
          end
        end
        default: begin
          cnt <= cnt;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      acc <= req_data.seed;
      bound <= req_data.bound;
    end else if (state == alr_pkg::ST_FILL) begin
      acc <= acc_next;
    end
    if (div_start) begin
      raw <= sum;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == alr_pkg::ST_MOD && !div_busy && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == alr_pkg::ST_MOD && !div_busy && rsp_free) begin
      rsp_data.raw_value <= raw;
      rsp_data.scaled_value <= (bound <= WW'(1)) ? '0 : div_rem;
    end
  end

  alr_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (sum),
    .divisor   (bound),
    .busy      (div_busy),
    .remainder (div_rem)
  );

`ifndef ASSERT_OFF
  // Rear index trails the front index by one word, cyclically
  a_rear_trails: assert property (@(posedge clk) disable iff (rst)
    front == ((rear == IW'(RING_SIZE - 1)) ? '0 : rear + IW'(1)))
    else $error("rear index not one behind front index");

  // The remainder unit is never restarted mid-operation
  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("remainder unit started while busy");

  // A new result only comes out of the remainder wait
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == alr_pkg::ST_MOD)
    else $error("result raised outside the remainder wait");

  // A draw for the caller never counts down the shuffle
  a_draw_no_count: assert property (@(posedge clk) disable iff (rst)
    (state == alr_pkg::ST_WRITE && !shuffle) |=> $stable(cnt))
    else $error("shuffle count changed on a caller draw");
`endif

endmodule

FILE: sim/alr_checker.sv
// Checker for the additive lagged generator: watches both channels, predicts draws, compares.
`timescale 1ns / 1ps

module alr_checker #(
  parameter int unsigned RING_SIZE = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  alr_pkg::req_t req_data,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  alr_pkg::rsp_t rsp_data,
  output int            fail_count,
  output int            draws_pending,
  output int            draws_checked,
  output int            reseeds_seen
);

  localparam int unsigned IDX_W = (RING_SIZE > 1) ? $clog2(RING_SIZE) : 1;
  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(RING_SIZE - 1);

  // Local copy of the generator state
  logic [alr_pkg::WORD_W-1:0] ring [RING_SIZE];
  logic [IDX_W-1:0]           front_pos;
  logic [IDX_W-1:0]           rear_pos;

  // Draw results predicted but not yet seen on the result channel
  alr_pkg::rsp_t expected_draws [$];

  // One additive step: front word absorbs rear word, both pointers move on.
  function automatic logic [alr_pkg::WORD_W-1:0] step_ring();
    logic [alr_pkg::WORD_W-1:0] sum;
    sum = ring[front_pos] + ring[rear_pos];
    ring[front_pos] = sum;
    if (front_pos == LAST_POS) begin
      front_pos = '0;
      // unchecked advance; rear trails front so it never passes the end here
      rear_pos = rear_pos + 1'b1;
    end else begin
      front_pos = front_pos + 1'b1;
      rear_pos = (rear_pos == LAST_POS) ? '0 : rear_pos + 1'b1;
    end
    return sum;
  endfunction

  // Fill the ring from the seed with the LCG, then discard the warm-up draws.
  function automatic void reseed_ring(input logic [alr_pkg::WORD_W-1:0] seed);
    ring[0] = seed;
    for (int i = 1; i < RING_SIZE; i++) begin
      ring[i] = alr_pkg::SEED_MULT * ring[i-1] + alr_pkg::SEED_ADD;
    end
    front_pos = IDX_W'(1);
    rear_pos = '0;
    repeat (alr_pkg::SHUFFLE_ROUNDS * RING_SIZE) void'(step_ring());
  endfunction

  // Expected result of one draw with the given bound.
  function automatic alr_pkg::rsp_t predict_draw(input logic [alr_pkg::WORD_W-1:0] bound);
    alr_pkg::rsp_t r;
    r.raw_value = step_ring();
    r.scaled_value = (bound <= 1) ? '0 : r.raw_value % bound;
    return r;
  endfunction

  // Channel monitor: results are matched first so a stray one is never hidden
  always @(posedge clk) begin
    alr_pkg::rsp_t want;
    int            errs;
    errs = fail_count;
    if (rst) begin
      for (int i = 0; i < RING_SIZE; i++) ring[i] = '0;
      front_pos = IDX_W'(1);
      rear_pos = '0;
      expected_draws.delete();
      errs = 0;
      draws_checked <= 0;
      reseeds_seen <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_draws.size() == 0) begin
          $error("result with no draw outstanding: scaled_value %h raw_value %h",
                 rsp_data.scaled_value, rsp_data.raw_value);
          errs++;
        end else begin
          want = expected_draws.pop_front();
          if (rsp_data.raw_value !== want.raw_value) begin
            $error("raw_value: expected %h, got %h", want.raw_value, rsp_data.raw_value);
            errs++;
          end
          if (rsp_data.scaled_value !== want.scaled_value) begin
            $error("scaled_value: expected %h, got %h",
                   want.scaled_value, rsp_data.scaled_value);
            errs++;
          end
          draws_checked <= draws_checked + 1;
        end
      end
      if (req_valid && !req_stall) begin
        if (req_data.action == alr_pkg::ACT_RESEED) begin
          reseed_ring(req_data.seed);
          reseeds_seen <= reseeds_seen + 1;
        end else begin
          expected_draws.push_back(predict_draw(req_data.bound));
        end
      end
    end
    fail_count <= errs;
    draws_pending <= expected_draws.size();
  end

endmodule

FILE: sim/tb.sv
// Top-level testbench for the additive lagged generator: stimulus, flow control, verdict.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned RING_SIZE = 32;
  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_ITEMS = 1750;
  localparam int PRESSURE_CYCLES = 400;
  // a reseed runs its fill and shuffle and gives no result
  localparam int DRAIN_CYCLES = 21 * RING_SIZE + 40;
  localparam int CYCLE_LIMIT = 2_000_000;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  alr_pkg::req_t req_data = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  alr_pkg::rsp_t rsp_data;

  int fail_count;
  int draws_pending;
  int draws_checked;
  int reseeds_seen;
  int requests_sent = 0;
  int quiet_left = 0;
  int cycle_count = 0;

  additive_lagged_rng_top #(.RING_SIZE(RING_SIZE)) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data (rsp_data)
  );

  alr_checker #(.RING_SIZE(RING_SIZE)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_data     (req_data),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .rsp_data     (rsp_data),
    .fail_count   (fail_count),
    .draws_pending(draws_pending),
    .draws_checked(draws_checked),
    .reseeds_seen (reseeds_seen)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Bound mix: tiny, small, powers of two, shifted random, near max, full random
  function automatic logic [alr_pkg::WORD_W-1:0] pick_bound();
    logic [alr_pkg::WORD_W-1:0] b;
    int unsigned kind;
    kind = $urandom_range(0, 5);
    case (kind)
      0: b = $urandom_range(0, 1);
      1: b = $urandom_range(2, 16);
      2: b = 32'd1 << $urandom_range(1, 31);
      3: b = $urandom >> $urandom_range(0, 31);
      4: b = 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: b = $urandom;
    endcase
    return b;
  endfunction

  // Sender idle: mostly none or short, a few long, with gap-free stretches
  task automatic sender_gap();
    int len;
    int pick;
    len = 0;
    pick = $urandom_range(0, 99);
    if (quiet_left > 0) begin
      quiet_left--;
    end else if (pick < 3) begin
      quiet_left = $urandom_range(20, 60);
    end else if (pick < 55) begin
      len = 0;
    end else if (pick < 85) begin
      len = $urandom_range(1, 3);
    end else if (pick < 97) begin
      len = $urandom_range(4, 12);
    end else begin
      len = $urandom_range(30, 80);
    end
    if (len > 0) begin
      req_valid <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  // Offer one request and hold it until taken
  task automatic send_request(input logic act, input logic [alr_pkg::WORD_W-1:0] seed,
                              input logic [alr_pkg::WORD_W-1:0] bound);
    alr_pkg::req_t r;
    r.action = act;
    r.seed = seed;
    r.bound = bound;
    req_valid <= 1'b1;
    req_data <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    requests_sent++;
    sender_gap();
  endtask

  // Result-side flow control: random stalls, one long hold after 20 checked draws, then random stalls
  initial begin
    int len;
    int mode;
    while (rst) @(posedge clk);
    while (draws_checked < 20) begin
      @(posedge clk);
      rsp_stall <= ($urandom_range(0, 3) == 0);
    end
    // long hold so the result register fills and the request side backs up
    repeat (PRESSURE_CYCLES) begin
      @(posedge clk);
      rsp_stall <= 1'b1;
    end
    forever begin
      mode = $urandom_range(0, 99);
      if (mode < 15) len = $urandom_range(20, 100);
      else if (mode < 20) len = $urandom_range(30, 150);
      else len = $urandom_range(1, 4);
      repeat (len) begin
        @(posedge clk);
        if (mode < 15) rsp_stall <= 1'b0;
        else if (mode < 20) rsp_stall <= 1'b1;
        else rsp_stall <= ($urandom_range(0, 2) == 0);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // draws from the all-zero ring left by reset
    send_request(alr_pkg::ACT_DRAW, 32'h0, 32'h0);
    send_request(alr_pkg::ACT_DRAW, 32'h0, 32'h1);
    send_request(alr_pkg::ACT_DRAW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // zero seed, then bound edges
    send_request(alr_pkg::ACT_RESEED, 32'h0, 32'h0);
    send_request(alr_pkg::ACT_DRAW, 32'h0, 32'h2);
    send_request(alr_pkg::ACT_DRAW, 32'h0, 32'h0);
    send_request(alr_pkg::ACT_DRAW, 32'h0, 32'h1);
    send_request(alr_pkg::ACT_DRAW, 32'h0, 32'hFFFF_FFFF);
    send_request(alr_pkg::ACT_DRAW, 32'h0, 32'h8000_0000);
    // all-ones seed; bound ignored on reseed, seed ignored on draw
    send_request(alr_pkg::ACT_RESEED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(alr_pkg::ACT_DRAW, 32'hFFFF_FFFF, 32'h3);
    send_request(alr_pkg::ACT_DRAW, 32'h1234_5678, 32'd10);
    send_request(alr_pkg::ACT_DRAW, 32'h0, 32'h7FFF_FFFF);
    // back-to-back reseeds
    send_request(alr_pkg::ACT_RESEED, 32'h1, 32'h0);
    send_request(alr_pkg::ACT_RESEED, 32'd12345, 32'h5);
    send_request(alr_pkg::ACT_DRAW, 32'h0, 32'hFFFF_FFFE);
    send_request(alr_pkg::ACT_DRAW, 32'h0, 32'h1);

    // random traffic, mostly draws so the pointers wrap many times
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 99) < 3) begin
        send_request(alr_pkg::ACT_RESEED, $urandom, $urandom);
      end else begin
        send_request(alr_pkg::ACT_DRAW, $urandom, pick_bound());
      end
    end
    req_valid <= 1'b0;

    @(posedge clk);
    while (draws_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d requests sent, %0d draws checked, %0d reseeds", requests_sent,
             draws_checked, reseeds_seen);
    $display("tb: covered bound edges, seed extremes, pointer wraps and a long result hold");
    if (fail_count == 0 && draws_pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
